/* hdl/ljpf_pkg.sv */
// shared constants, register index codes and saturating helpers for the
// lennard-jones pair force unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ljpf_pkg;

    localparam int MUL_W     = 64;
    localparam int PART_W    = MUL_W / 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int OUT_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS_X24      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_POW6   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_POW12  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 3'd5;

    localparam logic [CFG_W-1:0] RST_BOX_LENGTH   = 32'd655360;
    localparam logic [CFG_W-1:0] RST_EPS_X24      = 32'd1572864;
    localparam logic [CFG_W-1:0] RST_SIGMA_POW6   = 32'd65536;
    localparam logic [CFG_W-1:0] RST_SIGMA_POW12  = 32'd131072;
    localparam logic [CFG_W-1:0] RST_TIME_STEP    = 32'd66;
    localparam logic [CFG_W-1:0] RST_MIN_DISTANCE = 32'd32768;

    localparam logic [MUL_W-1:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [MUL_W-1:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;
    localparam logic [MUL_W-1:0] NEG_LIM = 64'h0000_0000_8000_0000;

    // product shifted right by a constant, clipped to 64 bits
    function automatic logic [MUL_W-1:0] sat64(input logic [2*MUL_W-1:0] p,
                                                input int unsigned k);
        logic [2*MUL_W-1:0] s;
        s = p >> k;
        return (s[2*MUL_W-1:MUL_W] != '0) ? '1 : s[MUL_W-1:0];
    endfunction

    function automatic logic [MUL_W-1:0] cap63(input logic [MUL_W-1:0] v);
        return v[MUL_W-1] ? MAX_S64 : v;
    endfunction

endpackage

`default_nettype wire

/* hdl/ljpf_mul64.sv */
// two-stage 64x64 unsigned multiplier built from four 32x32 partial products
// depends on ljpf_pkg
`timescale 1ns / 1ps
`default_nettype none

module ljpf_mul64 (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [ljpf_pkg::MUL_W-1:0]   i_a,
    input  wire logic [ljpf_pkg::MUL_W-1:0]   i_b,
    output logic      [2*ljpf_pkg::MUL_W-1:0] o_p
);
    import ljpf_pkg::*;

    logic [MUL_W-1:0]   r_p00, r_p01, r_p10, r_p11;
    logic [2*MUL_W-1:0] n_p;

    always_comb begin
        n_p = (2*MUL_W)'(r_p00)
            + ((2*MUL_W)'(r_p01) << PART_W)
            + ((2*MUL_W)'(r_p10) << PART_W)
            + ((2*MUL_W)'(r_p11) << MUL_W);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= i_a[PART_W-1:0]     * i_b[PART_W-1:0];
            r_p01 <= i_a[PART_W-1:0]     * i_b[MUL_W-1:PART_W];
            r_p10 <= i_a[MUL_W-1:PART_W] * i_b[PART_W-1:0];
            r_p11 <= i_a[MUL_W-1:PART_W] * i_b[MUL_W-1:PART_W];
            o_p   <= n_p;
        end
    end

endmodule

`default_nettype wire

/* hdl/lennard_jones_pair_force_unit.sv */
// pipeline: the square root retires one root bit per stage and the reciprocal one quotient bit
// per stage, the rest is minimum image, split 64-bit multiplies and clipping
// throughput: one pair per cycle; a stall at the output freezes the whole pipeline
// reset: synchronous, clears the valid line and loads the register defaults
// top level of the pair force unit; depends on ljpf_pkg and ljpf_mul64
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_pair_force_unit #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ljpf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ljpf_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // own_x, own_y, own_z, other_x, other_y, other_z, zero pad
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // own_valid, other_valid
    input  wire logic [1:0]                        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // impulse_x, impulse_y, impulse_z
    output logic [3*ljpf_pkg::OUT_W-1:0]            o_m_axis_tdata,
    // masked, saturated
    output logic [1:0]                             o_m_axis_tuser
);
    import ljpf_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = ((CW > CFG_W) ? CW : CFG_W) + 2;
    localparam int RB    = CW + 1;
    localparam int SW    = 2 * RB;
    localparam int SQ    = RB;
    localparam int REMW  = RB + 1;
    localparam int DVW   = (RB > CFG_W) ? RB : CFG_W;
    localparam int GB    = 2 * FRAC_BITS;
    localparam int KB    = FRAC_BITS + GB;
    localparam int QW    = KB + 1;
    localparam int QN    = QW;
    localparam int J_MAG = 16 + SQ + QN;
    localparam int N_SD  = 19 + SQ + QN;
    localparam int T_LAT = 22 + SQ + QN;
    localparam int V_CLAMP = 5 + SQ;

    typedef struct packed {
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic               masked;
    } t_side;

    function automatic logic [DW-1:0] absval(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // configuration
    logic [CFG_W-1:0]   r_box, r_eps, r_s6, r_s12, r_ts, r_rmin;
    logic [MUL_W-1:0]   r_te;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box  <= RST_BOX_LENGTH;
            r_eps  <= RST_EPS_X24;
            r_s6   <= RST_SIGMA_POW6;
            r_s12  <= RST_SIGMA_POW12;
            r_ts   <= RST_TIME_STEP;
            r_rmin <= RST_MIN_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_LENGTH:   r_box  <= i_cfg_data;
                CFG_EPS_X24:      r_eps  <= i_cfg_data;
                CFG_SIGMA_POW6:   r_s6   <= i_cfg_data;
                CFG_SIGMA_POW12:  r_s12  <= i_cfg_data;
                CFG_TIME_STEP:    r_ts   <= i_cfg_data;
                CFG_MIN_DISTANCE: r_rmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_te <= MUL_W'(r_ts) * MUL_W'(r_eps);
    end

    // pipeline advance and valid line
    logic             w_adv;
    logic [T_LAT-1:0] r_v;

    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_v[T_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[T_LAT-2:0], i_s_axis_tvalid};
        end
    end

    // stage a: raw displacement and its two wrapped candidates
    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] r_dm [3];
    logic signed [DW-1:0] r_dp [3];
    logic                 r_vin;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int ax = 0; ax < 3; ax++) begin
                r_d[ax]  <= $signed(DW'(i_s_axis_tdata[(ax+3)*CW +: CW]))
                          - $signed(DW'(i_s_axis_tdata[ax*CW +: CW]));
                r_dm[ax] <= $signed(DW'(i_s_axis_tdata[(ax+3)*CW +: CW]))
                          - $signed(DW'(i_s_axis_tdata[ax*CW +: CW]))
                          - $signed(DW'(r_box));
                r_dp[ax] <= $signed(DW'(i_s_axis_tdata[(ax+3)*CW +: CW]))
                          - $signed(DW'(i_s_axis_tdata[ax*CW +: CW]))
                          + $signed(DW'(r_box));
            end
            r_vin <= i_s_axis_tuser[0] & i_s_axis_tuser[1];
        end
    end

    // stage b: pick the strictly smallest magnitude
    t_side n_b, r_b;

    always_comb begin
        logic [DW-1:0] m0, m1, m2;
        logic          tie;
        tie = 1'b0;
        n_b = '0;
        for (int ax = 0; ax < 3; ax++) begin
            m0 = absval(r_d[ax]);
            m1 = absval(r_dm[ax]);
            m2 = absval(r_dp[ax]);
            if (m0 < m1 && m0 < m2) begin
                n_b.mag[ax] = CW'(m0);
                n_b.neg[ax] = r_d[ax][DW-1];
            end else if (m1 < m0 && m1 < m2) begin
                n_b.mag[ax] = CW'(m1);
                n_b.neg[ax] = r_dm[ax][DW-1];
            end else if (m2 < m0 && m2 < m1) begin
                n_b.mag[ax] = CW'(m2);
                n_b.neg[ax] = r_dp[ax][DW-1];
            end else begin
                tie = 1'b1;
            end
        end
        n_b.masked = !r_vin || tie;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b <= n_b;
        end
    end

    // side information travels beside the arithmetic
    t_side r_sd [N_SD];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd[0] <= r_b;
            for (int j = 1; j < N_SD; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
    end

    // squares and their sum
    logic [2*MUL_W-1:0] w_sqp [3];

    for (genvar ax = 0; ax < 3; ax++) begin : g_sq
        ljpf_mul64 u_sq (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (MUL_W'(r_b.mag[ax])),
            .i_b   (MUL_W'(r_b.mag[ax])),
            .o_p   (w_sqp[ax])
        );
    end

    // square root, one root bit per stage
    logic [SW-1:0]   r_sq_rad  [SQ+1];
    logic [REMW-1:0] r_sq_rem  [SQ+1];
    logic [RB-1:0]   r_sq_root [SQ+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_rad[0]  <= SW'(w_sqp[0]) + SW'(w_sqp[1]) + SW'(w_sqp[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar j = 0; j < SQ; j++) begin : g_sqrt
        logic [REMW+1:0] n_rem2;
        logic [REMW+1:0] n_trial;
        logic            n_ge;

        always_comb begin
            n_rem2  = {r_sq_rem[j], r_sq_rad[j][SW-1:SW-2]};
            n_trial = (REMW+2)'({r_sq_root[j], 2'b01});
            n_ge    = n_rem2 >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_rad[j+1]  <= r_sq_rad[j] << 2;
                r_sq_rem[j+1]  <= n_ge ? REMW'(n_rem2 - n_trial) : REMW'(n_rem2);
                r_sq_root[j+1] <= {r_sq_root[j][RB-2:0], n_ge};
            end
        end
    end

    // clamp, then reciprocal 2^(F+G) / r one quotient bit per stage
    logic [DVW-1:0] r_rc_d   [QN+1];
    logic [DVW-1:0] r_rc_rem [QN+1];
    logic [QW-1:0]  r_rc_q   [QN+1];
    logic [DVW-1:0] n_clamp;

    always_comb begin
        n_clamp = DVW'(r_sq_root[SQ]);
        if (n_clamp < DVW'(r_rmin)) begin
            n_clamp = DVW'(r_rmin);
        end
        if (n_clamp == '0) begin
            n_clamp = DVW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rc_d[0]   <= n_clamp;
            r_rc_rem[0] <= '0;
            r_rc_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QN; j++) begin : g_recip
        logic [DVW:0] n_rem2;
        logic         n_ge;

        always_comb begin
            n_rem2 = {r_rc_rem[j], 1'(j == 0)};
            n_ge   = n_rem2 >= {1'b0, r_rc_d[j]};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rc_d[j+1]   <= r_rc_d[j];
                r_rc_rem[j+1] <= n_ge ? DVW'(n_rem2 - {1'b0, r_rc_d[j]}) : DVW'(n_rem2);
                r_rc_q[j+1]   <= {r_rc_q[j][QW-2:0], n_ge};
            end
        end
    end

    logic [QW+MUL_W-1:0] w_qext;
    logic [MUL_W-1:0]    w_i1;

    assign w_qext = (QW+MUL_W)'(r_rc_q[QN]);
    assign w_i1   = (w_qext[QW+MUL_W-1:MUL_W] != '0) ? '1 : w_qext[MUL_W-1:0];

    // power chain of the inverse distance
    logic [2*MUL_W-1:0] w_p2, w_p4, w_p8, w_p6, w_p14, w_pt6, w_pt12, w_ps;
    logic [MUL_W-1:0]   w_i2, w_i4, w_i8, w_i6, w_i14;
    logic [MUL_W-1:0]   r_i2d [2];
    logic [MUL_W-1:0]   r_t6d [2];

    assign w_i2  = sat64(w_p2, GB);
    assign w_i4  = sat64(w_p4, GB);
    assign w_i8  = sat64(w_p8, GB);
    assign w_i6  = sat64(w_p6, GB);
    assign w_i14 = sat64(w_p14, GB);

    ljpf_mul64 u_m2 (.i_clk(i_clk), .i_en(w_adv), .i_a(w_i1), .i_b(w_i1), .o_p(w_p2));
    ljpf_mul64 u_m4 (.i_clk(i_clk), .i_en(w_adv), .i_a(w_i2), .i_b(w_i2), .o_p(w_p4));
    ljpf_mul64 u_m8 (.i_clk(i_clk), .i_en(w_adv), .i_a(w_i4), .i_b(w_i4), .o_p(w_p8));
    ljpf_mul64 u_m6 (.i_clk(i_clk), .i_en(w_adv), .i_a(w_i4), .i_b(r_i2d[1]), .o_p(w_p6));
    ljpf_mul64 u_m14 (.i_clk(i_clk), .i_en(w_adv), .i_a(w_i8), .i_b(w_i6), .o_p(w_p14));
    ljpf_mul64 u_mt6 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (MUL_W'(r_s6)),
        .i_b   (w_i8),
        .o_p   (w_pt6)
    );
    ljpf_mul64 u_mt12 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (MUL_W'(r_s12)),
        .i_b   (w_i14),
        .o_p   (w_pt12)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_i2d[0] <= w_i2;
            r_i2d[1] <= r_i2d[0];
            r_t6d[0] <= cap63(sat64(w_pt6, FRAC_BITS));
            r_t6d[1] <= r_t6d[0];
        end
    end

    // difference of the two terms as sign and magnitude
    logic [MUL_W-1:0] w_t12;
    logic [MUL_W-1:0] r_dif;
    logic             r_negs;
    logic [3:0]       r_negd;

    assign w_t12 = cap63(sat64(w_pt12, FRAC_BITS));

    // the sign waits out the scale and impulse multiplies
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_negs <= r_t6d[1] > w_t12;
            r_dif  <= (r_t6d[1] > w_t12) ? (r_t6d[1] - w_t12) : (w_t12 - r_t6d[1]);
            r_negd <= {r_negd[2:0], r_negs};
        end
    end

    ljpf_mul64 u_ms (.i_clk(i_clk), .i_en(w_adv), .i_a(r_dif), .i_b(r_te), .o_p(w_ps));

    logic [MUL_W-1:0] w_smag;
    assign w_smag = sat64(w_ps, 2 * FRAC_BITS);

    // per-axis impulse and clipping
    logic [2*MUL_W-1:0] w_pi [3];

    for (genvar ax = 0; ax < 3; ax++) begin : g_imp
        ljpf_mul64 u_mi (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (MUL_W'(r_sd[J_MAG].mag[ax])),
            .i_b   (w_smag),
            .o_p   (w_pi[ax])
        );
    end

    logic [3*OUT_W-1:0] n_data;
    logic [1:0]         n_user;

    always_comb begin
        logic [MUL_W-1:0] pm;
        logic             neg;
        n_data = '0;
        n_user = '0;
        for (int ax = 0; ax < 3; ax++) begin
            pm  = sat64(w_pi[ax], GB);
            neg = r_negd[3] ^ r_sd[N_SD-1].neg[ax];
            if (!neg && pm > POS_LIM) begin
                n_data[ax*OUT_W +: OUT_W] = OUT_W'(POS_LIM);
                n_user[1] = 1'b1;
            end else if (neg && pm > NEG_LIM) begin
                n_data[ax*OUT_W +: OUT_W] = OUT_W'(NEG_LIM);
                n_user[1] = 1'b1;
            end else if (neg) begin
                n_data[ax*OUT_W +: OUT_W] = ~pm[OUT_W-1:0] + OUT_W'(1);
            end else begin
                n_data[ax*OUT_W +: OUT_W] = pm[OUT_W-1:0];
            end
        end
        if (r_sd[N_SD-1].masked) begin
            n_data = '0;
            n_user = 2'b01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_m_axis_tdata <= n_data;
            o_m_axis_tuser <= n_user;
        end
    end

    // masked results carry no force and no clip flag
    a_masked_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0 && !o_m_axis_tuser[1])
        else $error("masked result with nonzero payload");

    // a clip flag means some component sits at a rail
    a_sat_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tdata[OUT_W-1:0] == OUT_W'(POS_LIM) ||
            o_m_axis_tdata[OUT_W-1:0] == OUT_W'(NEG_LIM) ||
            o_m_axis_tdata[2*OUT_W-1:OUT_W] == OUT_W'(POS_LIM) ||
            o_m_axis_tdata[2*OUT_W-1:OUT_W] == OUT_W'(NEG_LIM) ||
            o_m_axis_tdata[3*OUT_W-1:2*OUT_W] == OUT_W'(POS_LIM) ||
            o_m_axis_tdata[3*OUT_W-1:2*OUT_W] == OUT_W'(NEG_LIM))
        else $error("clip flag without railed component");

    // divisor into the reciprocal never zero
    a_div_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[V_CLAMP] |-> r_rc_d[0] != '0)
        else $error("zero divisor in reciprocal");

    // a stalled output freezes the valid line
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(r_v))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire
